@@ rtl/fqr_pkg.sv @@
// Package for the FIFO queue with delete-by-id and reverse.
// Types, codes and defaults shared by the controller, datapath and top level.
// No dependencies.
package fqr_pkg;

	localparam int DEF_QUEUE_DEPTH = 16;
	localparam int DEF_ID_BITS     = 16;

	localparam int MODE_W   = 2;
	localparam int CLIENT_W = 16;
	localparam int STATUS_W = 2;
	localparam int OCC_W    = 5;

	typedef enum logic [MODE_W-1:0] {
		MODE_APPEND  = 2'd0,
		MODE_TAKE    = 2'd1,
		MODE_DELETE  = 2'd2,
		MODE_REVERSE = 2'd3
	} mode_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK        = 2'd0,
		ST_EMPTY     = 2'd1,
		ST_NOT_FOUND = 2'd2,
		ST_FULL      = 2'd3
	} status_t;

	typedef enum logic [3:0] {
		C_IDLE,
		C_APPEND,
		C_TAKE_RD,
		C_TAKE_FIN,
		C_DEL_STEP,
		C_DEL_FIN,
		C_REV_CHK,
		C_REV_RD,
		C_REV_WA,
		C_REV_WB,
		C_EMIT
	} ctl_state_t;

	typedef enum logic [3:0] {
		DP_NOP,
		DP_LOAD,
		DP_APPEND,
		DP_TAKE_RD,
		DP_TAKE_FIN,
		DP_DEL_STEP,
		DP_DEL_FIN,
		DP_REV_RD,
		DP_REV_WA,
		DP_REV_WB
	} dp_op_t;

	typedef struct packed {
		dp_op_t op;
		logic   emit;
	} dp_cmd_t;

	typedef struct packed {
		logic scan_last;
		logic rev_more;
		logic out_free;
	} dp_status_t;

endpackage

@@ rtl/fqr_ifs.sv @@
// Valid/ready channel interfaces for the command and response beats.
// Depends on fqr_pkg for field widths.
interface fqr_cmd_if import fqr_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [MODE_W-1:0]   mode;
	logic [CLIENT_W-1:0] client_id;

	modport source(output valid, mode, client_id, input ready);
	modport sink(input valid, mode, client_id, output ready);
endinterface

interface fqr_rsp_if import fqr_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [STATUS_W-1:0] status;
	logic [CLIENT_W-1:0] result_id;
	logic [OCC_W-1:0]    occupancy;

	modport source(output valid, status, result_id, occupancy, input ready);
	modport sink(input valid, status, result_id, occupancy, output ready);
endinterface

@@ rtl/fqr_ctrl.sv @@
// Controller state machine: sequences one command beat through the datapath.
// Depends on fqr_pkg.
module fqr_ctrl import fqr_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cmd_valid,
	input  logic [MODE_W-1:0] cmd_mode,
	output logic              cmd_ready,
	input  dp_status_t        st,
	output dp_cmd_t           dcmd
);

	ctl_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= C_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		cmd_ready = 1'b0;
		dcmd.op   = DP_NOP;
		dcmd.emit = 1'b0;
		unique case (state_q)
			C_IDLE: begin
				cmd_ready = 1'b1;
				if (cmd_valid) begin
					dcmd.op = DP_LOAD;
					unique case (mode_t'(cmd_mode))
						MODE_APPEND:  state_d = C_APPEND;
						MODE_TAKE:    state_d = C_TAKE_RD;
						MODE_DELETE:  state_d = C_DEL_STEP;
						MODE_REVERSE: state_d = C_REV_CHK;
					endcase
				end
			end
			C_APPEND: begin
				dcmd.op = DP_APPEND;
				state_d = C_EMIT;
			end
			C_TAKE_RD: begin
				dcmd.op = DP_TAKE_RD;
				state_d = C_TAKE_FIN;
			end
			C_TAKE_FIN: begin
				dcmd.op = DP_TAKE_FIN;
				state_d = C_EMIT;
			end
			C_DEL_STEP: begin
				dcmd.op = DP_DEL_STEP;
				if (st.scan_last) begin
					state_d = C_DEL_FIN;
				end
			end
			C_DEL_FIN: begin
				dcmd.op = DP_DEL_FIN;
				state_d = C_EMIT;
			end
			C_REV_CHK: begin
				state_d = st.rev_more ? C_REV_RD : C_EMIT;
			end
			C_REV_RD: begin
				dcmd.op = DP_REV_RD;
				state_d = C_REV_WA;
			end
			C_REV_WA: begin
				dcmd.op = DP_REV_WA;
				state_d = C_REV_WB;
			end
			C_REV_WB: begin
				dcmd.op = DP_REV_WB;
				state_d = C_REV_CHK;
			end
			C_EMIT: begin
				if (st.out_free) begin
					dcmd.emit = 1'b1;
					state_d   = C_IDLE;
				end
			end
			default: begin
				state_d = C_IDLE;
			end
		endcase
	end

endmodule

@@ rtl/fqr_dp.sv @@
// Datapath: entry memory, head/count, scan and swap indexes, response register.
// Depends on fqr_pkg; driven by fqr_ctrl through dp_cmd_t / dp_status_t.
module fqr_dp import fqr_pkg::*; #(
	parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH,
	parameter int ID_BITS     = DEF_ID_BITS
) (
	input  logic                clk,
	input  logic                arst_n,
	input  dp_cmd_t             dcmd,
	output dp_status_t          st,
	input  logic [CLIENT_W-1:0] cmd_client_id,
	output logic                rsp_valid,
	input  logic                rsp_ready,
	output logic [STATUS_W-1:0] rsp_status,
	output logic [CLIENT_W-1:0] rsp_result_id,
	output logic [OCC_W-1:0]    rsp_occupancy
);

	localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam int SUM_W = $clog2(2 * QUEUE_DEPTH);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);
	localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(QUEUE_DEPTH - 1);

	logic [ID_BITS-1:0] store_q [QUEUE_DEPTH];
	logic [ID_BITS-1:0] rdata_a_q, rdata_b_q;

	logic [IDX_W-1:0]   head_q;
	logic [CNT_W-1:0]   count_q;
	logic [ID_BITS-1:0] id_q;
	logic [CNT_W-1:0]   i_q;
	logic [CNT_W-1:0]   lo_q, hi_q;
	logic               v_s1;
	logic [CNT_W-1:0]   pos_s1;
	logic               found_q;
	status_t            status_q;
	logic [ID_BITS-1:0] result_q;

	logic                out_valid_q;
	status_t             out_status_q;
	logic [CLIENT_W-1:0] out_result_q;
	logic [OCC_W-1:0]    out_occ_q;

	logic               we, rd_en;
	logic [IDX_W-1:0]   waddr, addr_a, addr_b;
	logic [ID_BITS-1:0] wdata;
	logic [31:0]        cid_ext, res_ext, cnt_ext;

	// logical position -> physical slot, head + pos stays below twice the depth
	function automatic logic [IDX_W-1:0] slot(input logic [IDX_W-1:0] head,
			input logic [CNT_W-1:0] pos);
		logic [SUM_W-1:0] sum;
		sum = SUM_W'(head) + SUM_W'(pos);
		if (sum >= SUM_W'(QUEUE_DEPTH)) begin
			sum = sum - SUM_W'(QUEUE_DEPTH);
		end
		return sum[IDX_W-1:0];
	endfunction

	assign cid_ext = 32'(cmd_client_id);
	assign res_ext = 32'(result_q);
	assign cnt_ext = 32'(count_q);

	assign st.scan_last = (i_q == count_q);
	assign st.rev_more  = (count_q > CNT_W'(1)) && (lo_q < hi_q);
	assign st.out_free  = !out_valid_q || rsp_ready;

	always_comb begin
		we     = 1'b0;
		rd_en  = 1'b0;
		waddr  = slot(head_q, count_q);
		wdata  = id_q;
		addr_a = head_q;
		addr_b = slot(head_q, hi_q);
		unique case (dcmd.op)
			DP_APPEND: begin
				we = (count_q != CNT_FULL);
			end
			DP_TAKE_RD: begin
				rd_en = 1'b1;
			end
			DP_DEL_STEP: begin
				rd_en  = (i_q < count_q);
				addr_a = slot(head_q, i_q);
				// once the match is behind us, every later entry moves up one place
				we     = v_s1 && found_q;
				waddr  = slot(head_q, pos_s1 - CNT_W'(1));
				wdata  = rdata_a_q;
			end
			DP_REV_RD: begin
				rd_en  = 1'b1;
				addr_a = slot(head_q, lo_q);
			end
			DP_REV_WA: begin
				we    = 1'b1;
				waddr = slot(head_q, lo_q);
				wdata = rdata_b_q;
			end
			DP_REV_WB: begin
				we    = 1'b1;
				waddr = slot(head_q, hi_q);
				wdata = rdata_a_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (we) begin
			store_q[waddr] <= wdata;
		end
		if (rd_en) begin
			rdata_a_q <= store_q[addr_a];
			rdata_b_q <= store_q[addr_b];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q      <= '0;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			unique case (dcmd.op)
				DP_APPEND: begin
					if (count_q != CNT_FULL) begin
						count_q <= count_q + CNT_W'(1);
					end
				end
				DP_TAKE_FIN: begin
					if (count_q != '0) begin
						head_q  <= (head_q == IDX_LAST) ? '0 : head_q + IDX_W'(1);
						count_q <= count_q - CNT_W'(1);
					end
				end
				DP_DEL_FIN: begin
					if (found_q) begin
						count_q <= count_q - CNT_W'(1);
					end
				end
				default: ;
			endcase
			if (dcmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (dcmd.op)
			DP_LOAD: begin
				id_q     <= cid_ext[ID_BITS-1:0];
				i_q      <= '0;
				v_s1     <= 1'b0;
				found_q  <= 1'b0;
				lo_q     <= '0;
				hi_q     <= count_q - CNT_W'(1);
				status_q <= ST_OK;
				result_q <= '0;
			end
			DP_APPEND: begin
				if (count_q == CNT_FULL) begin
					status_q <= ST_FULL;
				end
			end
			DP_TAKE_FIN: begin
				if (count_q == '0) begin
					status_q <= ST_EMPTY;
				end else begin
					result_q <= rdata_a_q;
				end
			end
			DP_DEL_STEP: begin
				v_s1   <= (i_q < count_q);
				pos_s1 <= i_q;
				if (i_q != count_q) begin
					i_q <= i_q + CNT_W'(1);
				end
				if (v_s1 && !found_q && (rdata_a_q == id_q)) begin
					found_q <= 1'b1;
				end
			end
			DP_DEL_FIN: begin
				if (found_q) begin
					result_q <= id_q;
				end else begin
					status_q <= ST_NOT_FOUND;
				end
			end
			DP_REV_WB: begin
				lo_q <= lo_q + CNT_W'(1);
				hi_q <= hi_q - CNT_W'(1);
			end
			default: ;
		endcase
		if (dcmd.emit) begin
			out_status_q <= status_q;
			out_result_q <= res_ext[CLIENT_W-1:0];
			out_occ_q    <= cnt_ext[OCC_W-1:0];
		end
	end

	assign rsp_valid     = out_valid_q;
	assign rsp_status    = out_status_q;
	assign rsp_result_id = out_result_q;
	assign rsp_occupancy = out_occ_q;

endmodule

@@ rtl/fifo_queue_remove_reverse.sv @@
// Top level: FIFO queue of ids with take, delete-by-id and reverse.
// Depends on fqr_pkg, fqr_ifs (fqr_cmd_if, fqr_rsp_if), fqr_ctrl and fqr_dp.
//
//   channel  dir  beat fields
//   cmd      in   mode[1:0], client_id[15:0]
//   rsp      out  status[1:0], result_id[15:0], occupancy[4:0]
//
// One command at a time, from the cmd beat to the rsp register load. Append
// writes the tail; take reads the head, then advances it; delete walks the
// entries and reverse swaps them pair by pair on the single-write memory port.
// Reset clears head, count and the response valid; entry contents are not cleared.
// A stalled rsp holds its beat; the next cmd is taken while it waits.
module fifo_queue_remove_reverse import fqr_pkg::*; #(
	parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH,
	parameter int ID_BITS     = DEF_ID_BITS
) (
	input logic      clk,
	input logic      arst_n,
	fqr_cmd_if.sink  cmd,
	fqr_rsp_if.source rsp
);

	dp_cmd_t    dcmd;
	dp_status_t dst;

	fqr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd.valid),
		.cmd_mode  (cmd.mode),
		.cmd_ready (cmd.ready),
		.st        (dst),
		.dcmd      (dcmd)
	);

	fqr_dp #(
		.QUEUE_DEPTH (QUEUE_DEPTH),
		.ID_BITS     (ID_BITS)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.dcmd          (dcmd),
		.st            (dst),
		.cmd_client_id (cmd.client_id),
		.rsp_valid     (rsp.valid),
		.rsp_ready     (rsp.ready),
		.rsp_status    (rsp.status),
		.rsp_result_id (rsp.result_id),
		.rsp_occupancy (rsp.occupancy)
	);

endmodule
